// File: src/jse_pkg.sv
// shared types, constants and helper functions of the json string escaper
package jse_pkg;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CTRL_MAX    = 8'h1f;

   localparam logic       ACTION_BYTE = 1'b0;
   localparam logic       ACTION_END  = 1'b1;

   localparam logic       ADD_QUOTES_RESET = 1'b1;

   localparam int QUEUE_DEPTH_DEF = 4;

   // step counter covers the longest run: opening quote plus six-byte escape
   localparam int STEP_W = 3;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_SHORT,
      KIND_UNICODE,
      KIND_CLOSE
   } kind_type;

   typedef struct packed {
      logic       action;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } rsp_type;

   // one classified item waiting for the back end
   typedef struct packed {
      logic       lead_quote;
      kind_type   kind;
      logic [7:0] data;
   } desc_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = CHAR_ZERO + {4'd0, v};
      end else begin
         r = CHAR_LOW_A + {4'd0, v} - 8'd10;
      end
      return r;
   endfunction

   function automatic logic [STEP_W-1:0] body_len(input kind_type k);
      logic [STEP_W-1:0] r;
      case (k)
         KIND_PLAIN:   r = STEP_W'(1);
         KIND_SHORT:   r = STEP_W'(2);
         KIND_UNICODE: r = STEP_W'(6);
         KIND_CLOSE:   r = STEP_W'(1);
         default:      r = STEP_W'(1);
      endcase
      return r;
   endfunction

endpackage

// File: src/json_string_escape_top.sv
// top level of the json string escaper
//
// Input channel req_*: one item per accepted cycle, either a raw string byte
// (action 0) or an end-of-string mark (action 1). Output channel rsp_*: one
// byte of escaped JSON text per accepted cycle; run_last marks the last byte
// an item causes, string_end marks the closing quote of a string.
// csr_*: one-bit write port for add_quotes (reset 1), always ready; write it
// only while the block is idle.
// An accepted item is written into the queue at the accepting edge; the back end
// reads the queue head combinationally and registers each byte it emits on rsp_*.
// Bytes per item: 1 for a plain byte, 2 for a short escape, 6 for a \u00hh
// escape, one more for an opening quote; the back end's step counter walks
// through them. An end mark in plain mode emits nothing and is not queued
// for the back end.
// The queue lets the front keep accepting items while the back end emits a
// long run; req_stall rises only when the queue is full.
// Reset clears the queue, the string state and the output valid, and sets
// add_quotes. While rsp_stall is high and rsp_valid is set, the output byte
// holds and the back end waits; the front keeps filling the queue.
module json_string_escape_top #(
   parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata,
   input  logic             req_valid,
   output logic             req_stall,
   input  jse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jse_pkg::rsp_type rsp_data
);
   import jse_pkg::*;

   logic     q_full, q_push, q_empty, q_pop;
   desc_type q_wdata, q_rdata;

   jse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   jse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/jse_front.sv
// front end: holds the quoting register and string state, classifies each item
module jse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  jse_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output jse_pkg::desc_type q_wdata
);
   import jse_pkg::*;

   logic add_quotes_ff, add_quotes_in;
   logic opened_ff, opened_in;
   logic accept;
   logic [7:0] b;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_data.in_byte;

   always_comb begin
      add_quotes_in = add_quotes_ff;
      if (csr_valid) begin
         add_quotes_in = csr_wdata;
      end
   end

   always_comb begin
      opened_in        = opened_ff;
      q_push           = 1'b0;
      q_wdata.lead_quote = 1'b0;
      q_wdata.kind     = KIND_PLAIN;
      q_wdata.data     = b;
      if (req_data.action == ACTION_BYTE) begin
         q_wdata.lead_quote = add_quotes_ff && !opened_ff;
         case (b)
            CHAR_QUOTE:  begin q_wdata.kind = KIND_SHORT; q_wdata.data = CHAR_QUOTE;  end
            CHAR_BSLASH: begin q_wdata.kind = KIND_SHORT; q_wdata.data = CHAR_BSLASH; end
            8'h08:       begin q_wdata.kind = KIND_SHORT; q_wdata.data = 8'h62; end
            8'h0c:       begin q_wdata.kind = KIND_SHORT; q_wdata.data = 8'h66; end
            8'h0a:       begin q_wdata.kind = KIND_SHORT; q_wdata.data = 8'h6e; end
            8'h0d:       begin q_wdata.kind = KIND_SHORT; q_wdata.data = 8'h72; end
            8'h09:       begin q_wdata.kind = KIND_SHORT; q_wdata.data = 8'h74; end
            default: begin
               if (b <= CTRL_MAX) begin
                  q_wdata.kind = KIND_UNICODE;
               end
            end
         endcase
         q_push = accept;
         if (accept && add_quotes_ff) begin
            opened_in = 1'b1;
         end
      end else begin
         // end mark in plain mode causes nothing downstream
         q_wdata.lead_quote = !opened_ff;
         q_wdata.kind       = KIND_CLOSE;
         q_push             = accept && add_quotes_ff;
         if (accept) begin
            opened_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_quotes_ff <= ADD_QUOTES_RESET;
         opened_ff     <= 1'b0;
      end else begin
         add_quotes_ff <= add_quotes_in;
         opened_ff     <= opened_in;
      end
   end

endmodule

// File: src/jse_queue.sv
// short queue of classified items between front and back end
module jse_queue #(
   parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jse_pkg::desc_type wdata,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output jse_pkg::desc_type rdata
);
   import jse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   desc_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/jse_back.sv
// back end: steps through each queued item and emits one output byte per cycle while not stalled
module jse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  jse_pkg::desc_type q_rdata,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jse_pkg::rsp_type  rsp_data
);
   import jse_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              advance, fire, last;
   logic [STEP_W-1:0] total, j;
   logic [7:0]        out_b;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = advance && !q_empty;
   assign total   = body_len(q_rdata.kind) + STEP_W'(q_rdata.lead_quote);
   assign last    = (step_ff == total - STEP_W'(1));
   assign j       = step_ff - STEP_W'(q_rdata.lead_quote);
   assign q_pop   = fire && last;

   always_comb begin
      out_b = q_rdata.data;
      if (q_rdata.lead_quote && step_ff == '0) begin
         out_b = CHAR_QUOTE;
      end else begin
         case (q_rdata.kind)
            KIND_PLAIN: out_b = q_rdata.data;
            KIND_SHORT: out_b = (j == '0) ? CHAR_BSLASH : q_rdata.data;
            KIND_UNICODE: begin
               case (j)
                  STEP_W'(0): out_b = CHAR_BSLASH;
                  STEP_W'(1): out_b = CHAR_U;
                  STEP_W'(2): out_b = CHAR_ZERO;
                  STEP_W'(3): out_b = CHAR_ZERO;
                  STEP_W'(4): out_b = hex_digit(q_rdata.data[7:4]);
                  default:    out_b = hex_digit(q_rdata.data[3:0]);
               endcase
            end
            KIND_CLOSE: out_b = CHAR_QUOTE;
            default:    out_b = q_rdata.data;
         endcase
      end
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fire) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_byte     = out_b;
         rsp_in.run_last     = last;
         rsp_in.string_end   = last && (q_rdata.kind == KIND_CLOSE);
         step_in             = last ? '0 : step_ff + STEP_W'(1);
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/jse_checker.sv
// port-level checks on the json string escaper, bound to the top level
module jse_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input jse_pkg::rsp_type rsp_data
);
   import jse_pkg::*;

   // a stalled output item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled output item changed");

   // the closing quote always ends its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_end |->
         rsp_data.run_last && rsp_data.out_byte == CHAR_QUOTE)
      else $error("string_end on a byte other than a final quote");

   // an output item never carries unknown bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("output item has unknown bits");

   // no output right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind json_string_escape_top jse_checker u_jse_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
